/* hdl/lbs_pkg.sv */
// Package for the linear blend skinning block: queue entry type, status
// struct, item codes and the saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

  localparam int QDEPTH     = 2;
  localparam int MAT_ELEMS  = 12;
  localparam int WGT_STEPS  = 6;
  localparam int TW         = 50;
  localparam int TLO        = 25;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_INFL  = 1'b1;
  localparam logic [1:0] ROW_NONE = 2'd3;
  localparam logic [1:0] COL_TRANS = 2'd3;

  typedef enum logic [1:0] {
    K_WRITE,
    K_APPLY,
    K_EMIT
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [5:0]         joint;
    logic [3:0]         off;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        weight;
    logic               last;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } bk_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic signed [31:0] r;
    if (a > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (a < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/lbs_in_if.sv */
// Input channel of the skinning block: valid/ready plus one item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [5:0]         joint_id;
  logic [16:0]        weight;
  logic               last_influence;
  logic [1:0]         matrix_row;
  logic [1:0]         matrix_col;
  logic signed [31:0] matrix_value;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, joint_id, weight,
                  last_influence, matrix_row, matrix_col, matrix_value,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, joint_id, weight,
                last_influence, matrix_row, matrix_col, matrix_value,
                output ready);
endinterface
`default_nettype wire

/* hdl/lbs_out_if.sv */
// Output channel of the skinning block: valid/ready plus skinned position.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

/* hdl/linear_blend_skinning_top.sv */
// Top level of the linear blend skinning block: front end, queue and back
// end. Depends on lbs_pkg, lbs_in_if, lbs_out_if, lbs_front and lbs_back.
`timescale 1ns / 1ps
`default_nettype none
// Matrix loads are written to the matrix RAM as the back end takes them. An
// influence with a nonzero weight on a valid joint makes twelve matrix reads
// from the single read port of the matrix RAM, streamed into one shared 33x33
// multiplier, then six partial products for the three weight multiplies on
// that same multiplier, and an emit step when it ends a vertex. Skipped
// influences that end a vertex take only the emit step; other skipped items
// never reach the back end. A result waits for the previous one to be taken.
// A two-entry queue sits between the input port and the back end, and a
// result register lets the next vertex start while the previous result waits.
// No clearing pass: the matrix store is undefined until written.
module linear_blend_skinning_top #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbs_in_if.sink    in_i,
  lbs_out_if.source out_o
);
  import lbs_pkg::*;

  entry_t     head;
  logic       head_valid;
  logic       pop;
  bk_status_t bk_status;

  lbs_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  lbs_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .status_o     (bk_status),
    .out_o        (out_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid) else $error("pop from empty queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !bk_status.busy) else $error("pop while back end busy");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(bk_status.emit))
    else $error("result without emit step");
`endif
endmodule
`default_nettype wire

/* hdl/lbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/lbs_front.sv */
// Front end: accepts input transactions, classifies them and queues the
// ones with work to do. Depends on lbs_pkg and lbs_in_if.
`timescale 1ns / 1ps
`default_nettype none
module lbs_front #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lbs_in_if.sink      in_i,
  output lbs_pkg::entry_t head_o,
  output logic        head_valid_o,
  input  wire logic   pop_i
);
  import lbs_pkg::*;

  entry_t     ent_q [QDEPTH];
  entry_t     ent_d;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       keep, in_range, accept, push;

  always_comb begin
    in_range    = 32'(in_i.joint_id) < MAX_JOINTS;
    ent_d.joint = in_i.joint_id;
    ent_d.off   = {in_i.matrix_row, in_i.matrix_col};
    ent_d.px    = in_i.pos_x;
    ent_d.py    = in_i.pos_y;
    ent_d.pz    = in_i.pos_z;
    ent_d.weight = in_i.weight;
    ent_d.last  = in_i.last_influence;
    ent_d.value = in_i.matrix_value;
    if (in_i.opcode == OP_LOAD) begin
      ent_d.kind = K_WRITE;
      keep       = in_range && (in_i.matrix_row != ROW_NONE);
    end else if (in_range && (in_i.weight != '0)) begin
      ent_d.kind = K_APPLY;
      keep       = 1'b1;
    end else begin
      ent_d.kind = K_EMIT;
      keep       = in_i.last_influence;
    end
  end

  assign in_i.ready   = cnt_q != 2'(QDEPTH);
  assign accept       = in_i.valid && in_i.ready;
  assign push         = accept && keep;
  assign head_o       = ent_q[rp_q];
  assign head_valid_o = cnt_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= ent_d;
    end
  end
endmodule
`default_nettype wire

/* hdl/lbs_back.sv */
// Back end: matrix store, shared multiplier, accumulators and result
// register. Depends on lbs_pkg, lbs_ram and lbs_out_if.
`timescale 1ns / 1ps
`default_nettype none
module lbs_back #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire lbs_pkg::entry_t head_i,
  input  wire logic   head_valid_i,
  output logic        pop_o,
  output lbs_pkg::bk_status_t status_o,
  lbs_out_if.source   out_o
);
  import lbs_pkg::*;

  localparam int NJ    = (MAX_JOINTS < 64) ? MAX_JOINTS : 64;
  localparam int DEPTH = NJ * MAT_ELEMS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_MAT, ST_WGT, ST_EMIT} st_e;

  st_e                state_q;
  entry_t             cur_q;
  logic [3:0]         ic_q, s1_ic_q, s2_ic_q;
  logic               s1_v_q, s2_v_q;
  logic [2:0]         j_q, wj_q;
  logic               wv_q;
  logic signed [63:0] acc_q [3];
  logic signed [TW-1:0] t_q [3];
  logic signed [65:0] prod_q, tmp_q;
  logic signed [31:0] m_q;
  logic               out_valid_q;
  logic signed [31:0] ox_q, oy_q, oz_q;

  logic               we, issue, wissue, emit, fire;
  logic [AW-1:0]      wbase, rbase, waddr, raddr;
  logic [31:0]        rdata;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] psel;
  logic signed [TW-1:0] tsel;
  logic signed [67:0] wsum;
  logic [1:0]         srow, wrow;

  assign wbase = (AW'(head_i.joint) << 3) + (AW'(head_i.joint) << 2);
  assign rbase = (AW'(cur_q.joint) << 3) + (AW'(cur_q.joint) << 2);
  assign waddr = wbase + AW'(head_i.off);
  assign raddr = rbase + AW'(ic_q);
  assign pop_o = (state_q == ST_IDLE) && head_valid_i;
  assign we    = pop_o && (head_i.kind == K_WRITE);

  lbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (head_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign issue  = (state_q == ST_MAT) && (ic_q < 4'(MAT_ELEMS));
  assign wissue = (state_q == ST_WGT) && (j_q < 3'(WGT_STEPS));
  assign emit   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign fire   = s1_v_q || wissue;
  assign srow   = s2_ic_q[3:2];
  assign wrow   = wj_q[2:1];

  always_comb begin
    case (s1_ic_q[1:0])
      2'd0:    psel = cur_q.px;
      2'd1:    psel = cur_q.py;
      default: psel = cur_q.pz;
    endcase
    tsel = t_q[j_q[2:1]];
    if (state_q == ST_WGT) begin
      mul_b = {16'd0, cur_q.weight};
      if (j_q[0]) begin
        mul_a = 33'($signed(tsel[TW-1:TLO]));
      end else begin
        mul_a = {8'd0, tsel[TLO-1:0]};
      end
    end else begin
      mul_a = 33'($signed(rdata));
      mul_b = 33'(psel);
    end
    mul_p = mul_a * mul_b;
    wsum  = ({{2{prod_q[65]}}, prod_q} <<< TLO) + {{2{tmp_q[65]}}, tmp_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ic_q        <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s1_ic_q     <= '0;
      s2_ic_q     <= '0;
      j_q         <= '0;
      wj_q        <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      s1_v_q  <= issue;
      s1_ic_q <= ic_q;
      s2_v_q  <= s1_v_q;
      s2_ic_q <= s1_ic_q;
      wv_q    <= wissue;
      wj_q    <= j_q;
      if (issue) begin
        ic_q <= ic_q + 4'd1;
      end
      if (wissue) begin
        j_q <= j_q + 3'd1;
      end
      if (wv_q && wj_q[0]) begin
        acc_q[wrow] <= acc_q[wrow] + 64'(wsum >>> 16);
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            ic_q <= '0;
            if (head_i.kind == K_APPLY) begin
              state_q <= ST_MAT;
            end else if (head_i.kind == K_EMIT) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_MAT: begin
          if (s2_v_q && (s2_ic_q == 4'(MAT_ELEMS - 1))) begin
            j_q     <= '0;
            state_q <= ST_WGT;
          end
        end
        ST_WGT: begin
          if (wv_q && (wj_q == 3'(WGT_STEPS - 1))) begin
            state_q <= cur_q.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            for (int i = 0; i < 3; i++) begin
              acc_q[i] <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= '0;
      end
    end
    if (fire) begin
      prod_q <= mul_p;
    end
    m_q <= $signed(rdata);
    if (s2_v_q) begin
      if (s2_ic_q[1:0] == COL_TRANS) begin
        t_q[srow] <= t_q[srow] + TW'(m_q);
      end else begin
        t_q[srow] <= t_q[srow] + TW'(prod_q >>> 16);
      end
    end
    if (wv_q && !wj_q[0]) begin
      tmp_q <= prod_q;
    end
    if (emit) begin
      ox_q <= sat32(acc_q[0]);
      oy_q <= sat32(acc_q[1]);
      oz_q <= sat32(acc_q[2]);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_x = ox_q;
  assign out_o.out_y = oy_q;
  assign out_o.out_z = oz_q;
  assign status_o.busy = state_q != ST_IDLE;
  assign status_o.emit = emit;
endmodule
`default_nettype wire
